// ----- rtl/slfr_pkg.sv -----
`timescale 1ns / 1ps
package slfr_pkg;

  // Input beat kinds (in_tuser)
  localparam logic [1:0] KIND_RX_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_READ    = 2'd3;

  // Result event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_STORED   = 3'd1;
  localparam logic [2:0] EV_COMPLETE = 3'd2;
  localparam logic [2:0] EV_DROPPED  = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT_MS  = 2'd0;
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd1;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd2;

  localparam logic [7:0] TIMEOUT_RST     = 8'd60;
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;

  // Frame layout: two sync bytes, two free bytes, length byte, payload, check byte
  localparam int unsigned HEADER_BYTES = 5;
  localparam int unsigned CHECK_BYTES  = 1;
  localparam logic [7:0]  IDLE_MAX     = 8'd255;

  typedef enum logic [2:0] {
    PS_IDLE  = 3'b001,
    PS_SYNC2 = 3'b010,
    PS_DATA  = 3'b100
  } parse_state_t;

endpackage

// ----- rtl/sync_length_frame_receiver.sv -----
`timescale 1ns / 1ps
// Frame receiver for a UART byte stream. Frames open with two configurable sync
// bytes, carry a length byte at offset 4 and total 5 + length + 1 bytes; they are
// assembled into a ring of SLOT_COUNT slots of FRAME_BYTES bytes in one frame
// memory. Input beats are received bytes, millisecond ticks, releases of the
// oldest full slot and reads of a byte of that slot; a gap of more ticks than
// timeout_ms before a byte discards a partial frame. Every input beat returns
// exactly one result beat. The block takes one beat per clock cycle while ready,
// and the result shows on the output in the cycle after the beat is taken: the
// frame memory does one access per beat (a byte write, or a byte read whose data
// is registered straight into the output stage). The output stage frees as it is
// taken, so the input stays ready while a result waits only if the output is
// taken that cycle. The frame memory needs no clearing after reset.
module sync_length_frame_receiver
  import slfr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 128,
  parameter int unsigned SLOT_COUNT  = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte[7:0], read_offset[14:8], zero [15]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // event_res[2:0], timed_out[3], slot[5:4], frame_length[14:6],
  // read_data[22:15], pending_frames[24:23], zero [31:25]
  output logic [31:0] out_tdata
);

  localparam int unsigned SW    = $clog2(SLOT_COUNT);
  localparam int unsigned IW    = $clog2(FRAME_BYTES + 1);
  localparam int unsigned XW    = $clog2(FRAME_BYTES);
  localparam int unsigned DEPTH = SLOT_COUNT * FRAME_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);

  // configuration
  logic [7:0] timeout_r, sync_first_r, sync_second_r;

  // frame memory
  logic [7:0] frame_mem [DEPTH];
  logic [7:0] rd_data_r;

  // parser and ring state
  logic [SLOT_COUNT-1:0] slot_full_r, slot_full_nxt;
  logic [8:0]            slot_len_r [SLOT_COUNT];
  logic [SW-1:0]         ws_r, ws_nxt, rs_r, rs_nxt;
  parse_state_t          ps_r, ps_nxt;
  logic [IW-1:0]         bi_r, bi_nxt;
  logic [7:0]            idle_r, idle_nxt;
  logic [8:0]            cur_len_r, cur_len_nxt;

  // output stage
  logic       out_valid_r;
  logic [2:0] ev_r, ev_nxt;
  logic       tmo_r, tmo_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [8:0] flen_r, flen_nxt;
  logic       rd_hit_r, rd_hit_nxt;
  logic [1:0] pend_r, pend_nxt;

  // per-beat decode
  logic          accept;
  logic [1:0]    kind;
  logic [7:0]    rx;
  logic [6:0]    off;
  parse_state_t  ps_eff;
  logic [IW-1:0] bi_eff, bi_inc;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [3:0]    full_cnt;
  logic          len_we;

  assign kind   = in_tuser;
  assign rx     = in_tdata[7:0];
  assign off    = in_tdata[14:8];
  assign accept = in_tvalid && in_tready;

  assign in_tready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, pend_r, (rd_hit_r ? rd_data_r : 8'd0), flen_r, slot_r,
                       tmo_r, ev_r};

  always_comb begin
    slot_full_nxt = slot_full_r;
    ws_nxt        = ws_r;
    rs_nxt        = rs_r;
    ps_nxt        = ps_r;
    bi_nxt        = bi_r;
    idle_nxt      = idle_r;
    cur_len_nxt   = cur_len_r;
    ev_nxt        = EV_NONE;
    tmo_nxt       = 1'b0;
    slot_nxt      = 2'(ws_r);
    flen_nxt      = 9'd0;
    rd_hit_nxt    = 1'b0;
    wr_en         = 1'b0;
    len_we        = 1'b0;
    ps_eff        = ps_r;
    bi_eff        = bi_r;
    bi_inc        = bi_r;

    case (kind)
      KIND_RX_BYTE: begin
        if (idle_r > timeout_r && ps_r != PS_IDLE) begin
          ps_eff  = PS_IDLE;
          bi_eff  = '0;
          tmo_nxt = 1'b1;
        end
        bi_inc = bi_eff + IW'(1);
        ps_nxt = ps_eff;
        bi_nxt = bi_eff;
        if (slot_full_r[ws_r]) begin
          // write slot still held by the consumer: drop and restart
          ev_nxt = EV_DROPPED;
          ps_nxt = PS_IDLE;
          bi_nxt = '0;
        end else begin
          idle_nxt = 8'd0;
          case (ps_eff)
            PS_IDLE: begin
              if (rx == sync_first_r) begin
                wr_en  = 1'b1;
                bi_nxt = bi_inc;
                ps_nxt = PS_SYNC2;
                ev_nxt = EV_STORED;
              end
            end
            PS_SYNC2: begin
              if (rx == sync_second_r) begin
                wr_en  = 1'b1;
                bi_nxt = bi_inc;
                ps_nxt = PS_DATA;
                ev_nxt = EV_STORED;
              end
            end
            PS_DATA: begin
              if (10'(bi_eff) >= 10'(FRAME_BYTES)) begin
                ev_nxt = EV_OVERFLOW;
                ps_nxt = PS_IDLE;
                bi_nxt = '0;
              end else begin
                wr_en  = 1'b1;
                bi_nxt = bi_inc;
                ev_nxt = EV_STORED;
                if (10'(bi_inc) == 10'(HEADER_BYTES)) begin
                  cur_len_nxt = 9'(HEADER_BYTES + CHECK_BYTES) + {1'b0, rx};
                end else if (10'(bi_inc) > 10'(HEADER_BYTES) &&
                             10'(bi_inc) >= 10'(cur_len_r)) begin
                  ev_nxt             = EV_COMPLETE;
                  flen_nxt           = cur_len_r;
                  len_we             = 1'b1;
                  slot_full_nxt[ws_r] = 1'b1;
                  ws_nxt = (ws_r == SW'(SLOT_COUNT - 1)) ? '0 : ws_r + SW'(1);
                  ps_nxt = PS_IDLE;
                  bi_nxt = '0;
                end
              end
            end
            default: begin
              ps_nxt = PS_IDLE;
              bi_nxt = '0;
            end
          endcase
        end
      end
      KIND_TICK: begin
        if (idle_r != IDLE_MAX) idle_nxt = idle_r + 8'd1;
      end
      KIND_RELEASE: begin
        slot_nxt = 2'(rs_r);
        if (slot_full_r[rs_r]) begin
          flen_nxt            = slot_len_r[rs_r];
          slot_full_nxt[rs_r] = 1'b0;
          rs_nxt = (rs_r == SW'(SLOT_COUNT - 1)) ? '0 : rs_r + SW'(1);
        end
      end
      KIND_READ: begin
        slot_nxt = 2'(rs_r);
        if (slot_full_r[rs_r]) begin
          flen_nxt   = slot_len_r[rs_r];
          rd_hit_nxt = 10'(off) < 10'(FRAME_BYTES);
        end
      end
      default: ;
    endcase

    full_cnt = 4'($countones(slot_full_nxt));
    pend_nxt = (full_cnt > 4'd3) ? 2'd3 : full_cnt[1:0];
  end

  assign wr_addr = AW'(FRAME_BYTES * ws_r + bi_eff[XW-1:0]);
  assign rd_addr = AW'(FRAME_BYTES * rs_r + off);

  // frame memory: one write or one registered read per beat
  always_ff @(posedge clk) begin
    if (accept && wr_en) frame_mem[wr_addr] <= rx;
    if (accept && rd_hit_nxt) rd_data_r <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && len_we) slot_len_r[ws_r] <= cur_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= TIMEOUT_RST;
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TIMEOUT_MS:  timeout_r     <= cfg_wdata;
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_full_r <= '0;
      ws_r        <= '0;
      rs_r        <= '0;
      ps_r        <= PS_IDLE;
      bi_r        <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        slot_full_r <= slot_full_nxt;
        ws_r        <= ws_nxt;
        rs_r        <= rs_nxt;
        ps_r        <= ps_nxt;
        bi_r        <= bi_nxt;
        idle_r      <= idle_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload and current frame length; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_len_r <= cur_len_nxt;
      ev_r      <= ev_nxt;
      tmo_r     <= tmo_nxt;
      slot_r    <= slot_nxt;
      flen_r    <= flen_nxt;
      rd_hit_r  <= rd_hit_nxt;
      pend_r    <= pend_nxt;
    end
  end

endmodule

// ----- dv/sync_length_frame_receiver_tb.sv -----
`timescale 1ns / 1ps
module sync_length_frame_receiver_tb
  import slfr_pkg::*;
();

  localparam int unsigned FRAME_BYTES = 128;
  localparam int unsigned SLOT_COUNT  = 3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEM_BUDGET    = 1550;
  localparam int PHASES         = 8;
  localparam int ROWS           = 18;

  // Field order matches out_tdata from the top bit down.
  typedef struct packed {
    logic [1:0] pending_frames;
    logic [7:0] read_data;
    logic [8:0] frame_length;
    logic [1:0] slot;
    logic       timed_out;
    logic [2:0] event_res;
  } rx_result_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [6:0] read_offset;
    logic       fixed;
    rx_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // rx_byte[7:0], read_offset[14:8], zero [15]
  logic [1:0]  in_tuser;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  // event_res[2:0], timed_out[3], slot[5:4], frame_length[14:6],
  // read_data[22:15], pending_frames[24:23], zero [31:25]
  logic [31:0] out_tdata;

  sync_length_frame_receiver #(
    .FRAME_BYTES(FRAME_BYTES),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Receiver state as the block should hold it.
  logic [7:0]   store_bytes   [FRAME_BYTES*SLOT_COUNT];
  bit           store_written [FRAME_BYTES*SLOT_COUNT];
  bit           slot_is_full  [SLOT_COUNT];
  logic [8:0]   slot_len      [SLOT_COUNT];
  int           wr_slot;
  int           rd_slot;
  int           byte_idx;
  parse_state_t parse_st;
  logic [7:0]   idle_ms;
  logic [7:0]   timeout_lim;
  logic [7:0]   sync_a;
  logic [7:0]   sync_b;

  rx_result_t awaited_results [$];
  int mismatch_count = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int idle_cycles    = 0;
  int in_mode        = 1;
  int out_mode       = 1;

  // kind, rx_byte, read_offset, fixed,
  // then pending_frames, read_data, frame_length, slot, timed_out, event_res
  stim_row_t directed_rows [ROWS] = '{
    {KIND_READ,    8'h00, 7'd127, 1'b1, 2'd0, 8'h00, 9'd0, 2'd0, 1'b0, EV_NONE},
    {KIND_RELEASE, 8'hFF, 7'd0,   1'b1, 2'd0, 8'h00, 9'd0, 2'd0, 1'b0, EV_NONE},
    {KIND_TICK,    8'h00, 7'd0,   1'b1, 2'd0, 8'h00, 9'd0, 2'd0, 1'b0, EV_NONE},
    {KIND_RX_BYTE, 8'h00, 7'd127, 1'b1, 2'd0, 8'h00, 9'd0, 2'd0, 1'b0, EV_NONE},
    {KIND_RX_BYTE, 8'hFF, 7'd0,   1'b1, 2'd0, 8'h00, 9'd0, 2'd0, 1'b0, EV_STORED},
    // not the second sync byte: ignored
    {KIND_RX_BYTE, 8'h00, 7'd0,   1'b1, 2'd0, 8'h00, 9'd0, 2'd0, 1'b0, EV_NONE},
    {KIND_RX_BYTE, 8'hFF, 7'd0,   1'b0, 25'd0},
    {KIND_RX_BYTE, 8'hAA, 7'd0,   1'b0, 25'd0},
    {KIND_RX_BYTE, 8'h5A, 7'd0,   1'b0, 25'd0},
    {KIND_RX_BYTE, 8'hA5, 7'd0,   1'b0, 25'd0},
    {KIND_RX_BYTE, 8'h00, 7'd0,   1'b0, 25'd0},
    // zero payload: the check byte closes a six byte frame
    {KIND_RX_BYTE, 8'hC3, 7'd0,   1'b1, 2'd1, 8'h00, 9'd6, 2'd0, 1'b0, EV_COMPLETE},
    {KIND_READ,    8'h00, 7'd0,   1'b0, 25'd0},
    {KIND_READ,    8'hFF, 7'd5,   1'b0, 25'd0},
    {KIND_TICK,    8'h00, 7'd0,   1'b0, 25'd0},
    {KIND_RELEASE, 8'h00, 7'd0,   1'b1, 2'd0, 8'h00, 9'd6, 2'd0, 1'b0, EV_NONE},
    {KIND_RELEASE, 8'h00, 7'd0,   1'b1, 2'd0, 8'h00, 9'd0, 2'd1, 1'b0, EV_NONE},
    {KIND_READ,    8'h00, 7'd127, 1'b0, 25'd0}
  };

  function automatic void reset_receiver_model();
    foreach (store_written[i]) begin
      store_written[i] = 1'b0;
      store_bytes[i]   = 8'h00;
    end
    foreach (slot_is_full[i]) begin
      slot_is_full[i] = 1'b0;
      slot_len[i]     = '0;
    end
    wr_slot     = 0;
    rd_slot     = 0;
    byte_idx    = 0;
    parse_st    = PS_IDLE;
    idle_ms     = '0;
    timeout_lim = TIMEOUT_RST;
    sync_a      = SYNC_FIRST_RST;
    sync_b      = SYNC_SECOND_RST;
  endfunction

  function automatic void keep_rx_byte(logic [7:0] b);
    store_bytes[wr_slot*FRAME_BYTES + byte_idx]   = b;
    store_written[wr_slot*FRAME_BYTES + byte_idx] = 1'b1;
    byte_idx++;
  endfunction

  function automatic void parser_to_idle();
    byte_idx = 0;
    parse_st = PS_IDLE;
  endfunction

  function automatic logic [1:0] full_slots();
    int n = 0;
    foreach (slot_is_full[i]) if (slot_is_full[i]) n++;
    return (n > 3) ? 2'd3 : n[1:0];
  endfunction

  function automatic rx_result_t receive_beat(logic [1:0] kind, logic [7:0] rx,
                                              logic [6:0] off);
    rx_result_t r;
    r = '0;
    case (kind)
      KIND_RX_BYTE: begin
        r.slot = wr_slot[1:0];
        if (idle_ms > timeout_lim && parse_st != PS_IDLE) begin
          parser_to_idle();
          r.timed_out = 1'b1;
        end
        if (slot_is_full[wr_slot]) begin
          r.event_res = EV_DROPPED;
          parser_to_idle();
        end else begin
          idle_ms = '0;
          case (parse_st)
            PS_IDLE: if (rx == sync_a) begin
              keep_rx_byte(rx);
              parse_st    = PS_SYNC2;
              r.event_res = EV_STORED;
            end
            PS_SYNC2: if (rx == sync_b) begin
              keep_rx_byte(rx);
              parse_st    = PS_DATA;
              r.event_res = EV_STORED;
            end
            default: begin
              if (byte_idx >= FRAME_BYTES) begin
                r.event_res = EV_OVERFLOW;
                parser_to_idle();
              end else begin
                keep_rx_byte(rx);
                r.event_res = EV_STORED;
                if (byte_idx == HEADER_BYTES) begin
                  slot_len[wr_slot] = 9'(HEADER_BYTES + rx + CHECK_BYTES);
                end else if (byte_idx > HEADER_BYTES && byte_idx >= slot_len[wr_slot]) begin
                  r.event_res           = EV_COMPLETE;
                  r.frame_length        = slot_len[wr_slot];
                  slot_is_full[wr_slot] = 1'b1;
                  wr_slot               = (wr_slot + 1) % SLOT_COUNT;
                  parser_to_idle();
                end
              end
            end
          endcase
        end
      end
      KIND_TICK: begin
        r.slot = wr_slot[1:0];
        if (idle_ms < IDLE_MAX) idle_ms++;
      end
      KIND_RELEASE: begin
        r.slot = rd_slot[1:0];
        if (slot_is_full[rd_slot]) begin
          r.frame_length        = slot_len[rd_slot];
          slot_is_full[rd_slot] = 1'b0;
          rd_slot               = (rd_slot + 1) % SLOT_COUNT;
        end
      end
      default: begin
        r.slot = rd_slot[1:0];
        if (slot_is_full[rd_slot]) begin
          r.frame_length = slot_len[rd_slot];
          r.read_data    = store_bytes[rd_slot*FRAME_BYTES + off];
        end
      end
    endcase
    r.pending_frames = full_slots();
    return r;
  endfunction

  function automatic int draw_wait(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  task automatic drive_beat(logic [1:0] kind, logic [7:0] rx, logic [6:0] off,
                            logic fixed, rx_result_t want);
    int gap;
    rx_result_t predicted;
    if ($urandom_range(0, 59) == 0) in_mode = $urandom_range(0, 2);
    gap = draw_wait(in_mode);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    // keep reads of a full slot on bytes that have been written
    if (kind == KIND_READ && slot_is_full[rd_slot] &&
        !store_written[rd_slot*FRAME_BYTES + off]) begin
      off = 7'($urandom_range(0, slot_len[rd_slot] - 1));
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, off, rx};
    do @(posedge clk); while (in_tready !== 1'b1);
    predicted = receive_beat(kind, rx, off);
    awaited_results.push_back(fixed ? want : predicted);
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) drive_beat(KIND_TICK, 8'($urandom), 7'($urandom), 1'b0, '0);
  endtask

  task automatic send_frame(bit broken);
    int len;
    int total;
    int cut;
    int pick;
    int stall_at;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 65) len = $urandom_range(0, 12);
    else if (pick < 85) len = $urandom_range(13, 121);
    else if (pick < 93) len = FRAME_BYTES - HEADER_BYTES - CHECK_BYTES;
    else len = $urandom_range(123, 255);
    total = HEADER_BYTES + len + CHECK_BYTES;
    cut = broken ? $urandom_range(1, total - 1) : total;
    // a gap right at the timeout threshold, rarer when the threshold is long
    stall_at = -1;
    if ($urandom_range(0, (timeout_lim > 64) ? 29 : 5) == 0) stall_at = $urandom_range(1, cut);
    for (int pos = 0; pos < cut; pos++) begin
      if (pos == stall_at) send_ticks(timeout_lim + $urandom_range(0, 1));
      else if (pos > 0 && $urandom_range(0, 24) == 0) send_ticks($urandom_range(1, 4));
      if (pos == 1 && $urandom_range(0, 9) == 0) begin
        drive_beat(KIND_RX_BYTE, 8'($urandom), 7'($urandom), 1'b0, '0);
      end
      case (pos)
        0:       b = sync_a;
        1:       b = sync_b;
        4:       b = len[7:0];
        default: b = 8'($urandom);
      endcase
      drive_beat(KIND_RX_BYTE, b, 7'($urandom), 1'b0, '0);
    end
  endtask

  task automatic read_oldest();
    repeat ($urandom_range(0, 4)) drive_beat(KIND_READ, 8'($urandom), 7'($urandom), 1'b0, '0);
    if ($urandom_range(0, 4) != 0)
      drive_beat(KIND_RELEASE, 8'($urandom), 7'($urandom), 1'b0, '0);
  endtask

  task automatic settle_receiver();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_registers(logic [7:0] tmo, logic [7:0] first, logic [7:0] second);
    logic [1:0] addr [3];
    logic [7:0] val  [3];
    addr = '{CFG_TIMEOUT_MS, CFG_SYNC_FIRST, CFG_SYNC_SECOND};
    val  = '{tmo, first, second};
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= addr[i];
      cfg_wdata <= val[i];
    end
    @(negedge clk);
    cfg_we      <= 1'b0;
    timeout_lim = tmo;
    sync_a      = first;
    sync_b      = second;
  endtask

  // Abort when neither side moves a beat for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sync_length_frame_receiver verification failed");
      $finish;
    end
  end

  initial begin : result_check
    int stall;
    rx_result_t got;
    rx_result_t want;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 59) == 0) out_mode = $urandom_range(0, 2);
      stall = draw_wait(out_mode);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got = out_tdata[24:0];
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = awaited_results.pop_front();
        if (got.event_res !== want.event_res)
          report_mismatch($sformatf("event_res %0d, expected %0d", got.event_res,
                                    want.event_res));
        if (got.timed_out !== want.timed_out)
          report_mismatch($sformatf("timed_out %0d, expected %0d", got.timed_out,
                                    want.timed_out));
        if (got.slot !== want.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
        if (got.frame_length !== want.frame_length)
          report_mismatch($sformatf("frame_length %0d, expected %0d", got.frame_length,
                                    want.frame_length));
        if (got.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %h, expected %h", got.read_data,
                                    want.read_data));
        if (got.pending_frames !== want.pending_frames)
          report_mismatch($sformatf("pending_frames %0d, expected %0d",
                                    got.pending_frames, want.pending_frames));
      end
    end
  end

  initial begin
    int phase_end;
    int pick;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    reset_receiver_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      drive_beat(directed_rows[i].kind, directed_rows[i].rx_byte,
                 directed_rows[i].read_offset, directed_rows[i].fixed,
                 directed_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle_receiver();
        case (ph)
          1:       write_registers(8'd0, 8'h00, 8'hFF);
          2:       write_registers(8'd255, 8'h5A, 8'h5A);
          3:       write_registers(8'd1, 8'hFF, 8'h00);
          4:       write_registers(TIMEOUT_RST, SYNC_FIRST_RST, SYNC_SECOND_RST);
          default: write_registers(($urandom_range(0, 3) == 0) ? 8'd255 :
                                   8'($urandom_range(0, 12)),
                                   8'($urandom), 8'($urandom));
        endcase
      end
      phase_end = items_sent + ITEM_BUDGET / PHASES;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        // drain more often as the ring fills up
        if (pick < 15 + 20 * full_slots()) read_oldest();
        else if (pick < 85) send_frame($urandom_range(0, 5) == 0);
        else begin
          repeat ($urandom_range(1, 4)) begin
            drive_beat(2'($urandom_range(0, 3)), 8'($urandom), 7'($urandom), 1'b0, '0);
          end
        end
      end
    end

    settle_receiver();
    if (mismatch_count == 0) begin
      $display("sync_length_frame_receiver verification clean");
    end else begin
      $display("sync_length_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
